// ===== rtl/core/circular_deque_macros.svh =====
// Assertion macros used by the deque sequencer RTL.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CDQ_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CDQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cdq_pkg.sv =====
// Types, constants and ring helpers for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int unsigned DEPTH    = 8;
    localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W    = ADDR_W + 1;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 4;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_REAR  = 3'd0,
        MODE_POP_FRONT  = 3'd1,
        MODE_PUSH_FRONT = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_DUMP       = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One result beat headed for the output register.
    typedef struct packed {
        logic               valid;
        t_status            status;
        t_word              data;
        logic               last;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

    // Memory request from the sequencer to the word store.
    typedef struct packed {
        logic   we;
        t_addr  wr_addr;
        t_word  wr_data;
        logic   re;
        t_addr  rd_addr;
    } t_mem_req;

    function automatic t_addr ring_next(input t_addr p);
        return (p == t_addr'(DEPTH - 1)) ? '0 : p + t_addr'(1);
    endfunction

    function automatic t_addr ring_prev(input t_addr p);
        return (p == '0) ? t_addr'(DEPTH - 1) : p - t_addr'(1);
    endfunction

    function automatic t_result make_res(input t_status st, input t_word d,
                                         input logic lst, input t_cnt cnt);
        t_result r;
        r.valid     = 1'b1;
        r.status    = st;
        r.data      = d;
        r.last      = lst;
        r.occupancy = OCC_W'(cnt);
        return r;
    endfunction

endpackage

// ===== rtl/core/cdq_if.sv =====
// Valid/ready channel interfaces for deque commands and results.
`timescale 1ns / 1ps

interface cdq_in_if;
    logic                              valid;
    logic                              ready;
    logic [cdq_pkg::MODE_W-1:0]        mode;
    logic signed [cdq_pkg::DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cdq_out_if;
    logic                              valid;
    logic                              ready;
    logic [cdq_pkg::STATUS_W-1:0]      status;
    logic signed [cdq_pkg::DATA_W-1:0] data;
    logic                              last;
    logic [cdq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output data, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input data, input last,
                    input occupancy, output ready);
endinterface

// ===== rtl/core/cdq_ram.sv =====
// Simple dual-port word store, registered read, no reset.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int unsigned DEPTH_P = 8,
    parameter int unsigned WIDTH_P = 32,
    localparam int unsigned AW = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [WIDTH_P-1:0] i_wr_data,
    input  logic               i_re,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [WIDTH_P-1:0] o_rd_data
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// Deque sequencer: ring pointers, fill count and memory access control.
`timescale 1ns / 1ps
`include "circular_deque_macros.svh"

module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdq_in_if.sink            i_in,
    input  logic              i_out_free,
    input  cdq_pkg::t_word    i_rd_data,
    output cdq_pkg::t_mem_req o_mem_req,
    output cdq_pkg::t_result  o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state            r_state, n_state;
    cdq_pkg::t_addr    r_head, n_head;
    cdq_pkg::t_addr    r_tail, n_tail;
    cdq_pkg::t_cnt     r_count, n_count;
    cdq_pkg::t_addr    r_ptr, n_ptr;
    cdq_pkg::t_cnt     r_left, n_left;

    cdq_pkg::t_mem_req w_mem_req;
    cdq_pkg::t_result  w_res;
    logic              w_in_ready;
    logic              w_full;
    logic              w_empty;
    logic              w_dump_last;
    logic [cdq_pkg::SUM_W-1:0] w_ring_sum;
    logic [cdq_pkg::SUM_W-1:0] w_ring_wrap;
    cdq_pkg::t_addr    w_ring_tail;

    assign w_in_ready  = (r_state == S_IDLE) && i_out_free;
    assign w_full      = (r_count == cdq_pkg::t_cnt'(cdq_pkg::DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_dump_last = (r_left == cdq_pkg::t_cnt'(1));

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_left    = r_left;
        w_mem_req = '0;
        w_res     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid && w_in_ready) begin
                    case (cdq_pkg::t_mode'(i_in.mode))
                        cdq_pkg::MODE_PUSH_REAR, cdq_pkg::MODE_PUSH_FRONT: begin
                            if (w_full) begin
                                w_res = cdq_pkg::make_res(cdq_pkg::ST_FULL, '0, 1'b1, r_count);
                            end else begin
                                w_mem_req.we      = 1'b1;
                                w_mem_req.wr_data = i_in.value;
                                if (cdq_pkg::t_mode'(i_in.mode) == cdq_pkg::MODE_PUSH_REAR) begin
                                    w_mem_req.wr_addr = r_tail;
                                    n_tail            = cdq_pkg::ring_next(r_tail);
                                end else begin
                                    n_head            = cdq_pkg::ring_prev(r_head);
                                    w_mem_req.wr_addr = n_head;
                                end
                                n_count = r_count + cdq_pkg::t_cnt'(1);
                                w_res   = cdq_pkg::make_res(cdq_pkg::ST_OK, '0, 1'b1, n_count);
                            end
                        end
                        cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_REAR: begin
                            if (w_empty) begin
                                w_res = cdq_pkg::make_res(cdq_pkg::ST_EMPTY, '0, 1'b1, r_count);
                            end else begin
                                w_mem_req.re = 1'b1;
                                if (cdq_pkg::t_mode'(i_in.mode) == cdq_pkg::MODE_POP_FRONT) begin
                                    w_mem_req.rd_addr = r_head;
                                    n_head            = cdq_pkg::ring_next(r_head);
                                end else begin
                                    n_tail            = cdq_pkg::ring_prev(r_tail);
                                    w_mem_req.rd_addr = n_tail;
                                end
                                n_count = r_count - cdq_pkg::t_cnt'(1);
                                n_state = S_POP;
                            end
                        end
                        cdq_pkg::MODE_DUMP: begin
                            if (w_empty) begin
                                w_res = cdq_pkg::make_res(cdq_pkg::ST_EMPTY, '0, 1'b1, r_count);
                            end else begin
                                w_mem_req.re      = 1'b1;
                                w_mem_req.rd_addr = r_head;
                                n_ptr             = cdq_pkg::ring_next(r_head);
                                n_left            = r_count;
                                n_state           = S_DUMP;
                            end
                        end
                        default: begin
                            // unused modes: drop the beat
                        end
                    endcase
                end
            end
            S_POP: begin
                // slot was free at accept, so the beat always lands
                w_res   = cdq_pkg::make_res(cdq_pkg::ST_OK, i_rd_data, 1'b1, r_count);
                n_state = S_IDLE;
            end
            S_DUMP: begin
                if (i_out_free) begin
                    w_res = cdq_pkg::make_res(cdq_pkg::ST_OK, i_rd_data, w_dump_last, r_count);
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_mem_req.re      = 1'b1;
                        w_mem_req.rd_addr = r_ptr;
                        n_ptr             = cdq_pkg::ring_next(r_ptr);
                        n_left            = r_left - cdq_pkg::t_cnt'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_left <= n_left;
    end

    assign i_in.ready = w_in_ready;
    assign o_mem_req  = w_mem_req;
    assign o_res      = w_res;

    // Tail must sit count entries past head around the ring.
    assign w_ring_sum  = cdq_pkg::SUM_W'(r_head) + cdq_pkg::SUM_W'(r_count);
    assign w_ring_wrap = (w_ring_sum >= cdq_pkg::SUM_W'(cdq_pkg::DEPTH))
                       ? w_ring_sum - cdq_pkg::SUM_W'(cdq_pkg::DEPTH) : w_ring_sum;
    assign w_ring_tail = w_ring_wrap[cdq_pkg::ADDR_W-1:0];

    `CDQ_ASSERT(a_count_max, 1'b1, r_count <= cdq_pkg::t_cnt'(cdq_pkg::DEPTH), "count over depth")
    `CDQ_ASSERT(a_ring_span, 1'b1, w_ring_tail == r_tail, "head, tail and count disagree")
    `CDQ_ASSERT(a_write_idle, w_mem_req.we, r_state == S_IDLE, "store written outside idle")
    `CDQ_ASSERT(a_emit_room, w_res.valid, i_out_free, "result emitted into a full slot")
    `CDQ_ASSERT_NXT(a_pop_done, r_state == S_POP, r_state == S_IDLE, "pop did not finish")

endmodule

// ===== rtl/core/circular_deque.sv =====
// Circular deque top level: sequencer, word store and output register.
`timescale 1ns / 1ps
// Push and every full/empty status appear in the cycle after accept; a pop result passes
//   the registered store read, then the output register, holding off the next command.
// Throughput: pushes and status-only items 1 per cycle while the sink takes each beat.
// Dump of N held words: one word per cycle from the store read port while the sink keeps up.
// Reset (sync, active low) clears ring pointers, count, sequencer and output valid; the word
//   store is not cleared and needs no clearing pass.

module circular_deque (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdq_in_if.sink    i_in,
    cdq_out_if.source o_out
);

    cdq_pkg::t_mem_req w_mem_req;
    cdq_pkg::t_result  w_res;
    cdq_pkg::t_word    w_rd_data;
    logic              w_out_free;

    // Output register: one beat parked here while the sink stalls.
    logic              r_out_valid;
    cdq_pkg::t_result  r_out_beat;

    // The slot frees up when empty or when its beat is taken this cycle.
    assign w_out_free = !r_out_valid || o_out.ready;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (w_out_free),
        .i_rd_data  (w_rd_data),
        .o_mem_req  (w_mem_req),
        .o_res      (w_res)
    );

    // Word store: one write or one read per cycle, read data registered and ready in the next cycle.
    cdq_ram #(
        .DEPTH_P (cdq_pkg::DEPTH),
        .WIDTH_P (cdq_pkg::DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_mem_req.we),
        .i_wr_addr (w_mem_req.wr_addr),
        .i_wr_data (w_mem_req.wr_data),
        .i_re      (w_mem_req.re),
        .i_rd_addr (w_mem_req.rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Advance the slot valid whenever the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res.valid;
        end
    end

    // Load payload only with a new beat; hold it otherwise.
    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res.valid) begin
            r_out_beat <= w_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_beat.status;
    assign o_out.data      = r_out_beat.data;
    assign o_out.last      = r_out_beat.last;
    assign o_out.occupancy = r_out_beat.occupancy;

endmodule
